[design/sitda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants
// Character codes, BCD adjust constants, queue depth and back-end states.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int CHAR_W      = 6;
    localparam int DIGIT_W     = 4;
    localparam int QUEUE_DEPTH = 2;

    // ASCII codes, kept to the six bits carried on the character port
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0]  ASCII_MINUS = 6'd45;

    // double-dabble adjust: a digit of five or more gets three added before the shift
    localparam logic [DIGIT_W-1:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ       = 4'd3;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CONV,
        BK_SCAN,
        BK_SIGN,
        BK_DIGIT
    } back_state_t;

endpackage

[design/sitda_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_front: input word classifier
// Split each signed word into a sign flag and an unsigned magnitude.
// ----------------------------------------------------------------------------
module sitda_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          value_valid,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          value_stall,
    input  logic                          queue_full,
    output logic                          push_valid,
    output logic [VALUE_WIDTH:0]          push_data
);
    import sitda_pkg::*;

    logic                   neg;
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;

    // magnitude is unsigned, so the most negative value maps to 2^(W-1)
    assign raw = value;
    assign neg = raw[VALUE_WIDTH-1];
    assign mag = neg ? (~raw + 1'b1) : raw;

    assign value_stall = queue_full;
    assign push_valid  = value_valid;
    assign push_data   = {neg, mag};

endmodule

[design/sitda_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_queue: short FIFO between front and back
// Hold classified words so the front keeps accepting while the back works.
// ----------------------------------------------------------------------------
module sitda_queue #(
    parameter int DATA_W = 33
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    output logic              pop_valid,
    output logic [DATA_W-1:0] pop_data,
    input  logic              pop
);
    import sitda_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/sitda_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_back: serial BCD converter and character emitter
// Convert a magnitude by shift-and-add-3, then send sign and digits out.
// ----------------------------------------------------------------------------
module sitda_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  logic [VALUE_WIDTH:0]         q_data,
    output logic                         q_pop,
    output logic [sitda_pkg::CHAR_W-1:0] character,
    output logic                         last,
    output logic                         result_valid,
    input  logic                         result_stall
);
    import sitda_pkg::*;

    // decimal digits of 2^(W-1): floor((W-1)*log10(2)) + 1
    localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int CNT_W      = $clog2(VALUE_WIDTH);

    back_state_t            state_reg, state_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;
    logic                   ovalid_reg, ovalid_next;

    logic                   out_load;
    logic                   conv_done;
    logic [BCD_W-1:0]       bcd_adj;
    logic [IDX_W-1:0]       top_idx;
    logic [DIGIT_W-1:0]     cur_digit;

    assign out_load  = !ovalid_reg || !result_stall;
    assign conv_done = (cnt_reg == CNT_W'(VALUE_WIDTH - 1));
    assign cur_digit = bcd_reg[{idx_reg, 2'b00} +: DIGIT_W];

    // add three to every digit of five or more, ahead of the shift
    always_comb
    begin
        logic [DIGIT_W-1:0] d;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d = bcd_reg[i*DIGIT_W +: DIGIT_W];
            if (d >= BCD_ADJ_LIMIT)
            begin
                d = d + BCD_ADJ;
            end
            bcd_adj[i*DIGIT_W +: DIGIT_W] = d;
        end
    end

    // most significant nonzero digit; zero keeps index zero
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] != '0)
            begin
                top_idx = IDX_W'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_CONV;
                end
            end
            BK_CONV:
            begin
                if (conv_done)
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                state_next = neg_reg ? BK_SIGN : BK_DIGIT;
            end
            BK_SIGN:
            begin
                if (out_load)
                begin
                    state_next = BK_DIGIT;
                end
            end
            BK_DIGIT:
            begin
                if (out_load && (idx_reg == '0))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        q_pop       = 1'b0;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        bcd_next    = bcd_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg && result_stall;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop    = q_valid;
                neg_next = q_data[VALUE_WIDTH];
                mag_next = q_data[VALUE_WIDTH-1:0];
                bcd_next = '0;
                cnt_next = '0;
            end
            BK_CONV:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
            end
            BK_SCAN:
            begin
                idx_next = top_idx;
            end
            BK_SIGN:
            begin
                if (out_load)
                begin
                    char_next   = ASCII_MINUS;
                    last_next   = 1'b0;
                    ovalid_next = 1'b1;
                end
            end
            BK_DIGIT:
            begin
                if (out_load)
                begin
                    char_next   = ASCII_ZERO + CHAR_W'(cur_digit);
                    last_next   = (idx_reg == '0);
                    ovalid_next = 1'b1;
                    if (idx_reg != '0)
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign character    = char_reg;
    assign last         = last_reg;
    assign result_valid = ovalid_reg;

endmodule

[design/signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Input channel (value_valid / value_stall / value) takes one two's complement
// word of VALUE_WIDTH bits. Output channel (result_valid / result_stall /
// character / last) gives its decimal text one character per word: a '-'
// first for negative values, then the digits most significant first with no
// leading zeros; zero gives a single '0'. last marks the final character.
// A word is moved when valid is high and stall is low at a rising edge.
// A two-entry queue sits behind the input, so up to two words are taken while
// the converter is busy. The converter takes a word from the queue, runs
// shift-and-add-3 over every magnitude bit, locates the leading digit, then
// sends one character per cycle while the output is not stalled.
// Reset (rst_n, asynchronous) empties the queue and the output register.
// A stall on the output holds the registered character in place and pauses
// the sign and digit emission; the queue keeps taking words until it fills.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          value_valid,
    output logic                          value_stall,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [sitda_pkg::CHAR_W-1:0]  character,
    output logic                          last
);
    import sitda_pkg::*;

    // sign flag on top, magnitude below
    logic                 push_valid;
    logic [VALUE_WIDTH:0] push_data;
    logic                 queue_full;
    logic                 pop_valid;
    logic [VALUE_WIDTH:0] pop_data;
    logic                 pop;

    // front: classify and hand off to the queue
    sitda_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .value_valid (value_valid),
        .value       (value),
        .value_stall (value_stall),
        .queue_full  (queue_full),
        .push_valid  (push_valid),
        .push_data   (push_data)
    );

    // queue: decouple acceptance from conversion
    sitda_queue #(
        .DATA_W (VALUE_WIDTH + 1)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop        (pop)
    );

    // back: convert serially and emit characters through the output register
    sitda_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (pop_valid),
        .q_data       (pop_data),
        .q_pop        (pop),
        .character    (character),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for signed_int_to_decimal_ascii
// Drives signed words into the converter and predicts the decimal text of
// each one as it is taken. Every character word that comes out is checked
// against the oldest predicted character. A short directed set covers the
// extremes, zero, the digit-count boundaries and the most negative value.
// Random words of every length follow. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    import sitda_pkg::*;

    localparam int W           = 32;
    localparam int RANDOM_WORDS = 250;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no word moved on either side
    localparam int DRAIN_CYCLES = 60;    // conversion plus one full run of characters

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 value_valid = 1'b0;
    logic                 value_stall;
    logic signed [W-1:0]  value = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [CHAR_W-1:0]    character;
    logic                 last;

    // words still to be offered, and characters owed by the converter
    logic signed [W-1:0]  value_backlog[$];
    text_char_t           text_due[$];

    int values_sent    = 0;
    int negatives_sent = 0;
    int chars_checked  = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    int send_gap  = 0;
    int send_calm = 0;
    int stall_left = 0;
    int recv_calm  = 0;

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH (W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .value_valid  (value_valid),
        .value_stall  (value_stall),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .character    (character),
        .last         (last)
    );

    always #5 clk = ~clk;

    // Work out the text of one word and append its characters to text_due.
    // The magnitude is taken unsigned so the most negative value needs no
    // special handling: its negation wraps to 2^(W-1), which is the answer.
    function automatic void predict_text(input logic signed [W-1:0] v);
        logic [W-1:0] mag;
        logic [3:0]   digits[20];
        int           nd;
        text_char_t   c;
        mag = v[W-1] ? W'(-v) : W'(v);
        nd  = 0;
        do begin
            digits[nd] = 4'(mag % 10);
            mag        = mag / 10;
            nd++;
        end while (mag != 0);
        if (v[W-1]) begin
            c.character = ASCII_MINUS;
            c.last      = 1'b0;
            text_due.push_back(c);
            negatives_sent++;
        end
        for (int k = nd - 1; k >= 0; k--) begin
            c.character = ASCII_ZERO + CHAR_W'(digits[k]);
            c.last      = (k == 0);
            text_due.push_back(c);
        end
    endfunction

    // Idle length: mostly none or short, now and then long; none at all
    // while a calm stretch is running.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Random word with a spread of digit counts: raw 32-bit patterns, values
    // of a chosen length, and values straddling a power of ten.
    function automatic logic signed [W-1:0] random_value();
        int          kind;
        int          k;
        longint      p;
        longint      hi;
        longint      lo;
        longint      mag;
        kind = $urandom_range(0, 9);
        if (kind < 3)
            return W'($urandom);
        k = $urandom_range(0, 9);
        p = 1;
        repeat (k) p = p * 10;
        if (kind < 8) begin
            hi  = (k == 9) ? 64'h7fff_ffff : p * 10 - 1;
            lo  = (k == 0) ? 0 : p;
            mag = lo + $urandom_range(0, 32'(hi - lo));
        end
        else begin
            mag = (k == 0) ? $urandom_range(0, 2) : p - 1 + $urandom_range(0, 2);
        end
        return $urandom_range(0, 1) ? W'(-mag) : W'(mag);
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer backlog words, predict each one at the edge it is
    // taken, hold the payload while stalled, and leave random gaps.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            value_valid <= 1'b0;
            value       <= '0;
            send_gap    <= 0;
            send_calm   <= 0;
        end
        else
        begin
            if (value_valid && !value_stall)
            begin
                predict_text(value);
                values_sent++;
            end

            // now and then run a stretch with no gaps at all
            if (send_calm > 0)
                send_calm <= send_calm - 1;
            else if ($urandom_range(0, 39) == 0)
                send_calm <= $urandom_range(20, 80);

            // a stalled word stays exactly as it is
            if (!(value_valid && value_stall))
            begin
                if (send_gap > 0)
                begin
                    value_valid <= 1'b0;
                    send_gap    <= send_gap - 1;
                end
                else if (value_backlog.size() > 0)
                begin
                    value       <= value_backlog.pop_front();
                    value_valid <= 1'b1;
                    send_gap    <= pick_gap(send_calm > 0);
                end
                else
                begin
                    value_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: check every character word taken against the oldest
    // prediction, and stall at random whether or not a word is on offer.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : receiver
        int         g;
        text_char_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
            recv_calm    <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (text_due.size() == 0)
                begin
                    $error("unexpected character word: character %0d last %0b",
                           character, last);
                    mismatches++;
                end
                else
                begin
                    want = text_due.pop_front();
                    if (character !== want.character)
                    begin
                        $error("character: expected %0d, actual %0d",
                               want.character, character);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, last);
                        mismatches++;
                    end
                    chars_checked++;
                end
            end

            if (recv_calm > 0)
                recv_calm <= recv_calm - 1;
            else if ($urandom_range(0, 39) == 0)
                recv_calm <= $urandom_range(20, 80);

            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left   <= stall_left - 1;
            end
            else if (recv_calm == 0 && $urandom_range(0, 2) == 0)
            begin
                g = pick_gap(1'b0);
                result_stall <= (g > 0);
                stall_left   <= (g > 0) ? g - 1 : 0;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: while work is outstanding, count cycles in which neither
    // channel moves a word; give up once the count reaches the limit.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n)
        begin
            if ((value_valid && !value_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else if (value_backlog.size() > 0 || text_due.size() > 0 || value_valid)
            begin
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("timeout: %0d cycles with no word moved", quiet_cycles);
                    $display("signed_int_to_decimal_ascii test failed");
                    $finish;
                end
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        // directed: zero, single digits, every power-of-ten boundary
        // worth seeing, both extremes and alternating bit patterns
        value_backlog.push_back(0);
        value_backlog.push_back(1);
        value_backlog.push_back(-1);
        value_backlog.push_back(9);
        value_backlog.push_back(-9);
        value_backlog.push_back(10);
        value_backlog.push_back(-10);
        value_backlog.push_back(99);
        value_backlog.push_back(100);
        value_backlog.push_back(12345);
        value_backlog.push_back(999_999_999);
        value_backlog.push_back(-999_999_999);
        value_backlog.push_back(1_000_000_000);
        value_backlog.push_back(-1_000_000_000);
        value_backlog.push_back(1_000_000_009);
        value_backlog.push_back(32'sh7fff_ffff);     // largest positive
        value_backlog.push_back(32'sh8000_0000);     // most negative
        value_backlog.push_back(32'sh8000_0001);
        value_backlog.push_back(32'sh5555_5555);
        value_backlog.push_back(32'shaaaa_aaaa);
        value_backlog.push_back(0);

        for (int i = 0; i < RANDOM_WORDS; i++)
            value_backlog.push_back(random_value());

        // hold reset, then release it away from the rising edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // advance until every word is taken and every character is back
        while (value_backlog.size() > 0 || value_valid || text_due.size() > 0)
            @(posedge clk);

        // allow time for any stray character to show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("converted %0d words (%0d negative) into %0d checked characters",
                 values_sent, negatives_sent, chars_checked);
        $display("random idling on input and output, %0d mismatches", mismatches);
        if (mismatches == 0 && text_due.size() == 0)
            $display("signed_int_to_decimal_ascii test passed");
        else
            $display("signed_int_to_decimal_ascii test failed");
        $finish;
    end

endmodule

[filelist.f]
design/sitda_pkg.sv
design/sitda_front.sv
design/sitda_queue.sv
design/sitda_back.sv
design/signed_int_to_decimal_ascii.sv
tb/tb.sv
